// ===== rtl/mfd_pkg.sv =====
package mfd_pkg;

  // fixed-point format of all scaled outputs
  localparam int FRAC_BITS = 16;

  // 2pi and pi in Q format, truncated
  localparam logic [20:0] TWO_PI_Q    = 21'((64'd628318 << FRAC_BITS) / 64'd100000);
  localparam logic [20:0] TWO_PI_Q_X2 = 21'(2 * TWO_PI_Q);
  localparam logic [20:0] PI_Q        = 21'((64'd314159 << FRAC_BITS) / 64'd100000);

  localparam int TURN_COUNT_WIDTH_DEF = 16;

  // code and limit widths of the three scaled quantities
  localparam int POS_CODE_BITS = 16;
  localparam int POS_LIM_BITS  = 20;
  localparam int SPD_CODE_BITS = 12;
  localparam int SPD_LIM_BITS  = 22;
  localparam int TRQ_CODE_BITS = 12;
  localparam int TRQ_LIM_BITS  = 20;

  // register map
  localparam logic [1:0] REG_POSITION_LIMIT   = 2'd0;
  localparam logic [1:0] REG_SPEED_LIMIT      = 2'd1;
  localparam logic [1:0] REG_TORQUE_LIMIT     = 2'd2;
  localparam logic [1:0] REG_SPEED_CLIP_LEVEL = 2'd3;

  localparam logic [19:0] POSITION_LIMIT_RST   = 20'd819200;
  localparam logic [21:0] SPEED_LIMIT_RST      = 22'd1966080;
  localparam logic [19:0] TORQUE_LIMIT_RST     = 20'd655360;
  localparam logic [21:0] SPEED_CLIP_LEVEL_RST = 22'd1932656;

  // status codes
  localparam logic [3:0] STATUS_DISABLED = 4'd0;
  localparam logic [3:0] STATUS_ENABLED  = 4'd1;

  // per-stage load enables of the scaling pipeline
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } mfd_stage_en_t;

  // fields that ride along the pipeline unchanged
  typedef struct packed {
    logic [3:0] status;
    logic [7:0] mos_temp;
    logic [7:0] rotor_temp;
  } mfd_meta_t;

endpackage

// ===== rtl/mfd_lin_map.sv =====
// floor(code * 2 * lim / (2^CODE_BITS - 1)) - lim over four stages
module mfd_lin_map import mfd_pkg::*; #(
  parameter int CODE_BITS = POS_CODE_BITS,
  parameter int LIM_BITS  = POS_LIM_BITS
) (
  input  logic                       clk,
  input  mfd_stage_en_t              en,
  input  logic [CODE_BITS-1:0]       code,
  input  logic [LIM_BITS-1:0]        lim,
  output logic signed [LIM_BITS:0]   value
);

  localparam int PW = CODE_BITS + LIM_BITS + 1;
  localparam int QW = LIM_BITS + 1;
  localparam int RW = CODE_BITS + 2;
  localparam logic [RW-1:0] DIV1 = RW'((1 << CODE_BITS) - 1);
  localparam logic [RW-1:0] DIV2 = RW'(2 * ((1 << CODE_BITS) - 1));

  logic [PW-1:0] prod2, prod3;
  logic [PW-1:0] prod_next;
  logic [QW-1:0] q3, q_next;
  logic [PW-1:0] rem_full;
  logic [RW-1:0] rem4;
  logic [QW:0]   qml4, qml_next;
  logic [1:0]    inc;
  logic [QW:0]   sum5;

  assign prod_next = PW'(code) * PW'({lim, 1'b0});

  // sum of the first two terms of x/2^n + x/2^2n + ..., low by at most two
  assign q_next = QW'(prod2 >> CODE_BITS) + QW'(prod2 >> (2 * CODE_BITS));

  assign rem_full = prod3 - {q3, {CODE_BITS{1'b0}}} + PW'(q3);
  assign qml_next = {1'b0, q3} - {2'b0, lim};

  assign inc  = {1'b0, (rem4 >= DIV1)} + {1'b0, (rem4 >= DIV2)};
  assign sum5 = qml4 + (QW + 1)'(inc);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      prod2 <= prod_next;
    end
    if (en.s3) begin
      prod3 <= prod2;
      q3    <= q_next;
    end
    if (en.s4) begin
      rem4 <= rem_full[RW-1:0];
      qml4 <= qml_next;
    end
    if (en.s5) begin
      value <= $signed(sum5[QW-1:0]);
    end
  end

endmodule

// ===== rtl/motor_feedback_frame_decoder.sv =====
// motor feedback frame decoder
//
// frame channel: one 64-bit feedback frame per request (frame_valid, frame_stall).
// result channel: status, scaled position / speed / torque in signed Q16, the
// two temperature bytes, turn count and position folded into plus or minus pi
// (result_valid, result_stall).
// configuration: APB-style port, four 32-bit limit registers at 0x0..0xC;
// write them only while no request is in flight.
//
// a request passes through the eight-stage pipeline (frame register,
// multiply, quotient estimate, remainder, correction, jump check, clip /
// modulo, fold) to the result port. throughput: one request per cycle
// while result_stall is low.
// each stage holds when it is full and the stage after it cannot take data,
// so bubbles collapse; frame_stall rises only when every stage is full and
// result_stall is high.
// reset: pipeline empties, limits return to their defaults, turn count and
// previous position clear to zero.
module motor_feedback_frame_decoder import mfd_pkg::*; #(
  parameter int TURN_COUNT_WIDTH = TURN_COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // frame channel
  input  logic               frame_valid,
  output logic               frame_stall,
  input  logic [63:0]        frame,
  // result channel
  output logic               result_valid,
  input  logic               result_stall,
  output logic [3:0]         motor_status,
  output logic signed [20:0] position,
  output logic signed [22:0] speed,
  output logic signed [20:0] torque,
  output logic [7:0]         mos_temperature,
  output logic [7:0]         rotor_temperature,
  output logic signed [15:0] turn_count,
  output logic signed [18:0] wrapped_position,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // jump thresholds for the turn counter
  localparam logic signed [21:0] JUMP_HI = $signed({1'b0, TWO_PI_Q});
  localparam logic signed [21:0] JUMP_LO = -JUMP_HI;

  // ---------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------
  logic [19:0] position_limit;
  logic [21:0] speed_limit;
  logic [19:0] torque_limit;
  logic [21:0] speed_clip_level;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      position_limit   <= POSITION_LIMIT_RST;
      speed_limit      <= SPEED_LIMIT_RST;
      torque_limit     <= TORQUE_LIMIT_RST;
      speed_clip_level <= SPEED_CLIP_LEVEL_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_POSITION_LIMIT:   position_limit   <= pwdata[19:0];
        REG_SPEED_LIMIT:      speed_limit      <= pwdata[21:0];
        REG_TORQUE_LIMIT:     torque_limit     <= pwdata[19:0];
        REG_SPEED_CLIP_LEVEL: speed_clip_level <= pwdata[21:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_POSITION_LIMIT:   prdata = {12'd0, position_limit};
      REG_SPEED_LIMIT:      prdata = {10'd0, speed_limit};
      REG_TORQUE_LIMIT:     prdata = {12'd0, torque_limit};
      REG_SPEED_CLIP_LEVEL: prdata = {10'd0, speed_clip_level};
      default:              prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // pipeline flow control: a stage loads when it is empty or its
  // successor loads too
  // ---------------------------------------------------------------
  logic [8:1] vld;
  logic [8:1] load;

  always_comb begin
    load[8] = !vld[8] || !result_stall;
    for (int k = 7; k >= 1; k--) begin
      load[k] = !vld[k] || load[k+1];
    end
  end

  assign frame_stall  = !load[1];
  assign result_valid = vld[8];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load[1]) begin
        vld[1] <= frame_valid;
      end
      for (int k = 2; k <= 8; k++) begin
        if (load[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // stage 1: frame register
  // ---------------------------------------------------------------
  logic [63:0] frame1;
  mfd_meta_t   meta1;

  always_ff @(posedge clk) begin
    if (load[1]) begin
      frame1 <= frame;
    end
  end

  // disabled status is reported as enabled
  always_comb begin
    meta1.status     = (frame1[63:60] == STATUS_DISABLED) ? STATUS_ENABLED : frame1[63:60];
    meta1.mos_temp   = frame1[15:8];
    meta1.rotor_temp = frame1[7:0];
  end

  // ---------------------------------------------------------------
  // stages 2..5: linear maps of the three codes
  // ---------------------------------------------------------------
  mfd_stage_en_t     map_en;
  logic signed [20:0] pos5;
  logic signed [22:0] spd5;
  logic signed [20:0] trq5;
  mfd_meta_t         meta2, meta3, meta4, meta5;

  assign map_en.s2 = load[2];
  assign map_en.s3 = load[3];
  assign map_en.s4 = load[4];
  assign map_en.s5 = load[5];

  mfd_lin_map #(
    .CODE_BITS (POS_CODE_BITS),
    .LIM_BITS  (POS_LIM_BITS)
  ) u_pos_map (
    .clk   (clk),
    .en    (map_en),
    .code  (frame1[55:40]),
    .lim   (position_limit),
    .value (pos5)
  );

  mfd_lin_map #(
    .CODE_BITS (SPD_CODE_BITS),
    .LIM_BITS  (SPD_LIM_BITS)
  ) u_spd_map (
    .clk   (clk),
    .en    (map_en),
    .code  (frame1[39:28]),
    .lim   (speed_limit),
    .value (spd5)
  );

  mfd_lin_map #(
    .CODE_BITS (TRQ_CODE_BITS),
    .LIM_BITS  (TRQ_LIM_BITS)
  ) u_trq_map (
    .clk   (clk),
    .en    (map_en),
    .code  (frame1[27:16]),
    .lim   (torque_limit),
    .value (trq5)
  );

  // status and temperatures ride along
  always_ff @(posedge clk) begin
    if (load[2]) meta2 <= meta1;
    if (load[3]) meta3 <= meta2;
    if (load[4]) meta4 <= meta3;
    if (load[5]) meta5 <= meta4;
  end

  // ---------------------------------------------------------------
  // stage 6: magnitudes and position jump check
  // ---------------------------------------------------------------
  logic signed [20:0] prev_position;
  logic signed [21:0] jump;
  logic [20:0]        pos_abs;
  logic [22:0]        spd_abs;

  logic signed [20:0] pos6;
  logic signed [22:0] spd6;
  logic signed [20:0] trq6;
  logic [20:0]        pos_mag6;
  logic [22:0]        spd_mag6;
  logic               step_dn6;
  logic               step_up6;
  mfd_meta_t          meta6;

  assign jump    = {pos5[20], pos5} - {prev_position[20], prev_position};
  assign pos_abs = pos5[20] ? $unsigned(-pos5) : $unsigned(pos5);
  assign spd_abs = spd5[22] ? $unsigned(-spd5) : $unsigned(spd5);

  always_ff @(posedge clk) begin
    if (load[6]) begin
      pos6     <= pos5;
      spd6     <= spd5;
      trq6     <= trq5;
      pos_mag6 <= pos_abs;
      spd_mag6 <= spd_abs;
      step_dn6 <= (jump > JUMP_HI);
      step_up6 <= (jump < JUMP_LO);
      meta6    <= meta5;
    end
  end

  // the first frame after reset measures its jump from zero
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_position <= '0;
    end else if (load[6] && vld[5]) begin
      prev_position <= pos5;
    end
  end

  // ---------------------------------------------------------------
  // stage 7: speed clip, turn count, position modulo 2pi
  // ---------------------------------------------------------------
  logic [TURN_COUNT_WIDTH-1:0]  wrap_count;
  logic [TURN_COUNT_WIDTH-1:0]  wrap_count_next;
  logic [TURN_COUNT_WIDTH+15:0] turn_ext;
  logic [20:0]                  pos_mod_next;

  logic signed [20:0] pos7;
  logic signed [22:0] spd7;
  logic signed [20:0] trq7;
  logic [20:0]        pos_mod7;
  logic               pos_neg7;
  logic [15:0]        turn7;
  mfd_meta_t          meta7;

  // a forward jump past 2pi counts down, a backward one counts up
  always_comb begin
    if (step_dn6) begin
      wrap_count_next = wrap_count - TURN_COUNT_WIDTH'(4);
    end else if (step_up6) begin
      wrap_count_next = wrap_count + TURN_COUNT_WIDTH'(4);
    end else begin
      wrap_count_next = wrap_count;
    end
  end

  assign turn_ext = {16'd0, wrap_count_next};

  // magnitude stays below three turns, so two trial subtractions cover it
  always_comb begin
    if (pos_mag6 >= TWO_PI_Q_X2) begin
      pos_mod_next = pos_mag6 - TWO_PI_Q_X2;
    end else if (pos_mag6 >= TWO_PI_Q) begin
      pos_mod_next = pos_mag6 - TWO_PI_Q;
    end else begin
      pos_mod_next = pos_mag6;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_count <= '0;
    end else if (load[7] && vld[6]) begin
      wrap_count <= wrap_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load[7]) begin
      pos7     <= pos6;
      spd7     <= (spd_mag6 >= {1'b0, speed_clip_level}) ? '0 : spd6;
      trq7     <= trq6;
      pos_mod7 <= pos_mod_next;
      pos_neg7 <= pos6[20];
      turn7    <= turn_ext[15:0];
      meta7    <= meta6;
    end
  end

  // ---------------------------------------------------------------
  // stage 8: fold into plus or minus pi, result register
  // ---------------------------------------------------------------
  logic signed [20:0] fold;
  logic signed [20:0] wrapped_next;

  // exactly pi is kept as is
  assign fold         = (pos_mod7 > PI_Q) ? $signed(pos_mod7 - TWO_PI_Q) : $signed(pos_mod7);
  assign wrapped_next = pos_neg7 ? -fold : fold;

  always_ff @(posedge clk) begin
    if (load[8]) begin
      motor_status      <= meta7.status;
      position          <= pos7;
      speed             <= spd7;
      torque            <= trq7;
      mos_temperature   <= meta7.mos_temp;
      rotor_temperature <= meta7.rotor_temp;
      turn_count        <= $signed(turn7);
      wrapped_position  <= wrapped_next[18:0];
    end
  end

endmodule
